// ===== rtl/lcpu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSTM pointwise update package
// Shared types, constants and the piecewise-linear activation functions.
// ----------------------------------------------------------------------------
package lcpu_pkg;

    localparam int GATES = 4;
    localparam int ONE_Q12 = 4096;

    // gate order in the bias memory and the lanes
    localparam int GATE_I = 0;
    localparam int GATE_G = 1;
    localparam int GATE_F = 2;
    localparam int GATE_O = 3;

    localparam logic CMD_COMPUTE = 1'b0;
    localparam logic CMD_LOAD    = 1'b1;

    localparam logic [1:0] REG_HIDDEN_SIZE = 2'd0;
    localparam logic [1:0] REG_TRAINING    = 2'd1;
    localparam logic [1:0] REG_ZO_ENABLE   = 2'd2;
    localparam logic [1:0] REG_ZO_PROB     = 2'd3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ACT,
        ST_CELL,
        ST_TANH,
        ST_HID,
        ST_ZONE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic training;
        logic zo_enable;
        logic [15:0] zo_prob;
    } t_cfg;

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        if (v > 34'sd32767) return 16'sh7fff;
        else if (v < -34'sd32768) return 16'sh8000;
        else return v[15:0];
    endfunction

    // sigmoid of a non-negative Q3.12 magnitude (up to 17 bits for tanh)
    function automatic logic [12:0] sigm_pos(input logic [16:0] a);
        logic [16:0] y;
        if (a >= 17'd20480) y = 17'd4096;
        else if (a >= 17'd9728) y = (a >> 5) + 17'd3456;
        else if (a >= 17'd4096) y = (a >> 3) + 17'd2560;
        else y = (a >> 2) + 17'd2048;
        return y[12:0];
    endfunction

    function automatic logic [12:0] sigm(input logic signed [15:0] x);
        logic [16:0] a;
        logic [12:0] y;
        a = x[15] ? 17'(-$signed({x[15], x})) : 17'({1'b0, x});
        y = sigm_pos(a);
        return x[15] ? 13'(13'd4096 - y) : y;
    endfunction

    function automatic logic signed [13:0] tanh_pwl(input logic signed [15:0] x);
        logic [16:0] a;
        logic signed [14:0] y;
        a = x[15] ? 17'(-$signed({x[15], x})) : 17'({1'b0, x});
        y = $signed({1'b0, sigm_pos(17'(a << 1)), 1'b0}) - 15'sd4096;
        return x[15] ? 14'(-y) : 14'(y);
    endfunction

endpackage

// ===== rtl/lcpu_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSTM gate lane
// Adds input term, recurrent term and bias, saturates, applies activation.
// ----------------------------------------------------------------------------
module lcpu_lane #(
    parameter bit IS_TANH = 1'b0
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_wx,
    input  logic signed [15:0] i_rh,
    input  logic signed [15:0] i_bias,
    output logic signed [13:0] o_act
);
    logic signed [15:0] w_pre;
    logic signed [13:0] r_act;

    assign w_pre = lcpu_pkg::sat16(34'(i_wx) + 34'(i_rh) + 34'(i_bias));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (IS_TANH) r_act <= lcpu_pkg::tanh_pwl(w_pre);
            else r_act <= $signed({1'b0, lcpu_pkg::sigm(w_pre)});
        end
    end

    assign o_act = r_act;
endmodule

// ===== rtl/lcpu_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSTM merge stage
// Combines the four gate values into c_new, h_new and applies zoneout.
// ----------------------------------------------------------------------------
module lcpu_merge (
    input  logic               i_clk,
    input  lcpu_pkg::t_state   i_state,
    input  lcpu_pkg::t_cfg     i_cfg,
    input  logic signed [13:0] i_gi,
    input  logic signed [13:0] i_gg,
    input  logic signed [13:0] i_gf,
    input  logic signed [13:0] i_go,
    input  logic signed [15:0] i_h_prev,
    input  logic signed [15:0] i_c_prev,
    input  logic [12:0]        i_mask,
    output logic signed [15:0] o_h,
    output logic signed [15:0] o_c
);
    logic signed [31:0] r_p0, r_p1, n_p0, n_p1;
    logic signed [15:0] r_c, r_h, n_c, n_h;
    logic signed [33:0] w_sum;
    logic signed [16:0] w_diff;
    logic [12:0] w_mask;
    logic signed [13:0] w_tc;

    assign w_sum = 34'(r_p0) + 34'(r_p1);
    assign w_diff = 17'(r_h) - 17'(i_h_prev);
    assign w_mask = (i_mask > 13'd4096) ? 13'd4096 : i_mask;
    assign w_tc = lcpu_pkg::tanh_pwl(r_c);

    always_comb begin
        n_p0 = r_p0;
        n_p1 = r_p1;
        n_c = r_c;
        n_h = r_h;
        unique case (i_state)
            lcpu_pkg::ST_ACT: begin
                n_p0 = 32'(i_gf) * 32'(i_c_prev);
                n_p1 = 32'(i_gi) * 32'(i_gg);
            end
            lcpu_pkg::ST_CELL: begin
                n_c = lcpu_pkg::sat16((w_sum + 34'sd2048) >>> 12);
            end
            // r_c holds the new cell value here
            lcpu_pkg::ST_TANH: begin
                n_p0 = 32'(i_go) * 32'(w_tc);
            end
            lcpu_pkg::ST_HID: begin
                n_h = lcpu_pkg::sat16((34'(r_p0) + 34'sd2048) >>> 12);
            end
            lcpu_pkg::ST_ZONE: begin
                if (i_cfg.training) begin
                    n_p0 = 32'(w_diff) * $signed({19'd0, w_mask});
                    n_p1 = 32'(i_h_prev) <<< 12;
                end else begin
                    n_p0 = $signed({16'd0, i_cfg.zo_prob}) * 32'(i_h_prev);
                    n_p1 = $signed({15'd0, 17'(17'h10000 - {1'b0, i_cfg.zo_prob})})
                           * 32'(r_h);
                end
            end
            default: ;
        endcase
    end

    logic signed [49:0] w_zsum;
    logic signed [15:0] w_zh;
    always_comb begin
        if (i_cfg.training) begin
            w_zsum = 50'(w_sum);
            w_zh = lcpu_pkg::sat16(34'((w_zsum + 50'sd2048) >>> 12));
        end else begin
            w_zsum = 50'(r_p0) + 50'(r_p1);
            w_zh = lcpu_pkg::sat16(34'((w_zsum + 50'sd32768) >>> 16));
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0 <= n_p0;
        r_p1 <= n_p1;
        r_c <= n_c;
        r_h <= (i_state == lcpu_pkg::ST_OUT && i_cfg.zo_enable) ? r_h : n_h;
    end

    assign o_c = r_c;
    assign o_h = i_cfg.zo_enable ? w_zh : r_h;
endmodule

// ===== rtl/lstm_cell_pointwise_update_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSTM cell pointwise update
// A compute beat runs through these steps in turn before its result is shown:
// accept with bias read, activation, gate products, cell rounding, hidden
// product, hidden rounding, zoneout products and output, which waits for
// m_axis_tready; a new beat is taken only in idle. A load beat leaves it idle.
// Reset: synchronous active low; clears config, state, row counter and output
// valid, sets hidden size to 1024; bias memory is undefined until written.
// ----------------------------------------------------------------------------
module lstm_cell_pointwise_update_top #(
    parameter int HIDDEN_MAX = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] wx_i, [31:16] wx_g, [47:32] wx_f, [63:48] wx_o, [79:64] rh_i,
    // [95:80] rh_g, [111:96] rh_f, [127:112] rh_o, [143:128] h_prev,
    // [159:144] c_prev, [172:160] zo_mask, zero fill to 176
    input  logic [175:0] s_axis_tdata,
    // [0] cmd
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] h_new, [31:16] c_new, [44:32] gate_i, [58:45] gate_g,
    // [71:59] gate_f, [84:72] gate_o (gates zero unless training), zero fill to 88
    output logic [87:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);
    localparam int ROW_W = (HIDDEN_MAX > 1) ? $clog2(HIDDEN_MAX) : 1;
    localparam int HS_W = 11;

    logic [HS_W-1:0] r_hidden;
    lcpu_pkg::t_cfg r_cfg;
    logic [ROW_W-1:0] r_row;
    lcpu_pkg::t_state r_state, n_state;
    logic [175:0] r_in;
    logic [15:0] r_bias [lcpu_pkg::GATES];
    logic [15:0] bias_mem [lcpu_pkg::GATES][HIDDEN_MAX];
    logic w_acc_in, w_load, w_lane_en, w_out_load;
    logic [HS_W-1:0] w_eff;
    logic [HS_W:0] w_row_nx;
    logic signed [13:0] w_act [lcpu_pkg::GATES];
    logic signed [15:0] w_h, w_c;
    logic [87:0] r_out;
    logic r_out_v;

    assign w_acc_in = s_axis_tvalid && s_axis_tready;
    assign w_load = s_axis_tuser == lcpu_pkg::CMD_LOAD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hidden <= 11'd1024;
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lcpu_pkg::REG_HIDDEN_SIZE: r_hidden <= i_cfg_data[HS_W-1:0];
                lcpu_pkg::REG_TRAINING:    r_cfg.training <= i_cfg_data[0];
                lcpu_pkg::REG_ZO_ENABLE:   r_cfg.zo_enable <= i_cfg_data[0];
                lcpu_pkg::REG_ZO_PROB:     r_cfg.zo_prob <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        if (r_hidden == '0) w_eff = 11'd1;
        else if (32'(r_hidden) > HIDDEN_MAX) w_eff = HS_W'(HIDDEN_MAX);
        else w_eff = r_hidden;
    end
    assign w_row_nx = (HS_W+1)'(r_row) + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_row <= '0;
        else if (w_acc_in)
            r_row <= (w_row_nx >= (HS_W+1)'(w_eff)) ? '0 : ROW_W'(w_row_nx);
    end

    // bias memory: one bank per gate, one write and one registered read
    always_ff @(posedge i_clk) begin
        for (int g = 0; g < lcpu_pkg::GATES; g++) begin
            if (w_acc_in && w_load) bias_mem[g][r_row] <= s_axis_tdata[g*16 +: 16];
            if (w_acc_in && !w_load) r_bias[g] <= bias_mem[g][r_row];
        end
        if (w_acc_in) r_in <= s_axis_tdata;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lcpu_pkg::ST_IDLE: if (w_acc_in && !w_load) n_state = lcpu_pkg::ST_READ;
            lcpu_pkg::ST_READ: n_state = lcpu_pkg::ST_ACT;
            lcpu_pkg::ST_ACT:  n_state = lcpu_pkg::ST_CELL;
            lcpu_pkg::ST_CELL: n_state = lcpu_pkg::ST_TANH;
            lcpu_pkg::ST_TANH: n_state = lcpu_pkg::ST_HID;
            lcpu_pkg::ST_HID:  n_state = lcpu_pkg::ST_ZONE;
            lcpu_pkg::ST_ZONE: n_state = lcpu_pkg::ST_OUT;
            lcpu_pkg::ST_OUT:  if (!r_out_v || m_axis_tready) n_state = lcpu_pkg::ST_IDLE;
            default: n_state = lcpu_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = r_state == lcpu_pkg::ST_IDLE;
        w_lane_en = r_state == lcpu_pkg::ST_READ;
        w_out_load = r_state == lcpu_pkg::ST_OUT && (!r_out_v || m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= lcpu_pkg::ST_IDLE;
        else r_state <= n_state;
    end

    for (genvar g = 0; g < lcpu_pkg::GATES; g++) begin : g_lane
        lcpu_lane #(.IS_TANH(g == lcpu_pkg::GATE_G)) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_lane_en),
            .i_wx   (r_in[g*16 +: 16]),
            .i_rh   (r_in[64 + g*16 +: 16]),
            .i_bias (r_bias[g]),
            .o_act  (w_act[g])
        );
    end

    lcpu_merge u_merge (
        .i_clk    (i_clk),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_gi     (w_act[lcpu_pkg::GATE_I]),
        .i_gg     (w_act[lcpu_pkg::GATE_G]),
        .i_gf     (w_act[lcpu_pkg::GATE_F]),
        .i_go     (w_act[lcpu_pkg::GATE_O]),
        .i_h_prev (r_in[143:128]),
        .i_c_prev (r_in[159:144]),
        .i_mask   (r_in[172:160]),
        .o_h      (w_h),
        .o_c      (w_c)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (w_out_load) r_out_v <= 1'b1;
        else if (m_axis_tready) r_out_v <= 1'b0;
        if (w_out_load) begin
            r_out <= r_cfg.training ?
                {3'd0, w_act[lcpu_pkg::GATE_O][12:0], w_act[lcpu_pkg::GATE_F][12:0],
                 w_act[lcpu_pkg::GATE_G], w_act[lcpu_pkg::GATE_I][12:0], w_c, w_h} :
                {56'd0, w_c, w_h};
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata = r_out;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == lcpu_pkg::ST_IDLE)
        else $error("ready outside idle");
    a_compute_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_in && !w_load) |=> r_state == lcpu_pkg::ST_READ)
        else $error("compute beat not started");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < HIDDEN_MAX)
        else $error("row out of range");
endmodule
